[rtl/core/target_position_drive_controller_macros.svh]
// Assertion macros used by the drive controller top level.
`ifndef TARGET_POSITION_DRIVE_CONTROLLER_MACROS_SVH
`define TARGET_POSITION_DRIVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TPDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpdc assertion failed");

// Next-cycle implication, disabled while in reset.
`define TPDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpdc assertion failed");

`endif

[rtl/core/tpdc_pkg.sv]
// Types and constants of the target position drive controller.
package tpdc_pkg;

  typedef struct packed {
    logic signed [23:0] position;
    logic               new_target;
    logic signed [23:0] target;
    logic [1:0]         set_mode;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] command;
    logic               mode_now;
  } out_beat_t;

  typedef struct packed {
    logic        go;
    logic [23:0] m;
  } ramp_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RAMP,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_MUL,
    R_SUM,
    R_SCALE
  } ramp_state_t;

  localparam logic [1:0] REQ_CAL    = 2'd1;
  localparam logic [1:0] REQ_NORMAL = 2'd2;

  localparam logic [1:0] REG_BASE_DUTY    = 2'd0;
  localparam logic [1:0] REG_DEAD_BAND    = 2'd1;
  localparam logic [1:0] REG_TRAVEL_LIMIT = 2'd2;
  localparam logic [1:0] REG_SLOW_DRIVE   = 2'd3;

  localparam logic        MODE_CAL    = 1'b0;
  localparam logic        MODE_NORMAL = 1'b1;

  localparam logic [15:0] FULL_DRIVE  = 16'd254;
  localparam logic [14:0] MAG_SAT     = 15'd32767;

  localparam logic [15:0] RST_BASE_DUTY    = 16'd10289;
  localparam logic [15:0] RST_DEAD_BAND    = 16'd197;
  localparam logic [22:0] RST_TRAVEL_LIMIT = 23'd3932160;
  localparam logic [7:0]  RST_SLOW_DRIVE   = 8'd60;

endpackage

[rtl/core/target_position_drive_controller.sv]
// Top level of the target position drive controller.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one beat per position
//   sample: position, optional new target, mode request. Each beat yields
//   exactly one result beat on out_valid/out_stall/out_data: the signed
//   PWM command and the mode in force after the sample.
//   Sequence: an accepted beat goes through EVAL, then DONE, where the
//   result is loaded into the output register and out_valid rises. A ramp
//   puts RAMP between them: the serial multiplier (one bit of the distance
//   per cycle), then sum and scale, then the handoff back to the control FSM.
//   Throughput: one sample at a time; in_stall is high from accept until
//   the result is loaded into the output register, and the next beat can be
//   accepted after that load. A result waiting on a stalled receiver does
//   not block the next sample from being accepted; only the load of the
//   following result waits, and in_stall stays high until it goes through.
//   Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12
//   (base_duty, dead_band, travel_limit, slow_drive). pready is always high.
//   Reset (rst_n low, synchronous): calibrate mode, all tracking state and
//   held command zero, registers to their defaults, output empty.
`include "target_position_drive_controller_macros.svh"

module target_position_drive_controller #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpdc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tpdc_pkg::out_beat_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tpdc_pkg::*;

  // thresholds in distance units
  localparam logic [27:0] ONE     = 28'd1 << FRAC_BITS;
  localparam logic [33:0] TGT_LIM = 34'd299 << FRAC_BITS;

  // config registers
  logic [15:0] base_duty_r, dead_band_r;
  logic [22:0] travel_limit_r;
  logic [7:0]  slow_drive_r;

  // control and tracking state
  ctl_state_t         state_r, state_nxt;
  in_beat_t           in_r;
  logic               run_mode_r, run_mode_nxt;
  logic signed [23:0] target_now_r, target_now_nxt;
  logic signed [23:0] target_good_r, target_good_nxt;
  logic [23:0]        peak_r, peak_nxt;
  logic signed [23:0] last_pos_r, last_pos_nxt;
  logic [31:0]        travel_r, travel_nxt;
  logic signed [15:0] held_r, held_nxt;
  logic               neg_r, neg_nxt;
  out_beat_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  ramp_req_t   ramp_req;
  logic        ramp_done;
  logic [14:0] ramp_mag;

  // evaluation datapath
  logic               mode_v;
  logic signed [23:0] tgt_v;
  logic signed [24:0] delta;
  logic [23:0]        ad;
  logic [23:0]        pk;
  logic [24:0]        move_diff;
  logic [23:0]        move;
  logic [32:0]        travel_sum;
  logic [31:0]        travel_sat;
  logic               load_out;
  logic               cfg_wr;

  tpdc_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ramp_req),
    .base_duty (base_duty_r),
    .done      (ramp_done),
    .mag       (ramp_mag)
  );

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_duty_r    <= RST_BASE_DUTY;
      dead_band_r    <= RST_DEAD_BAND;
      travel_limit_r <= RST_TRAVEL_LIMIT;
      slow_drive_r   <= RST_SLOW_DRIVE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASE_DUTY:    base_duty_r    <= pwdata[15:0];
        REG_DEAD_BAND:    dead_band_r    <= pwdata[15:0];
        REG_TRAVEL_LIMIT: travel_limit_r <= pwdata[22:0];
        REG_SLOW_DRIVE:   slow_drive_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASE_DUTY:    prdata = {16'd0, base_duty_r};
      REG_DEAD_BAND:    prdata = {16'd0, dead_band_r};
      REG_TRAVEL_LIMIT: prdata = {9'd0, travel_limit_r};
      REG_SLOW_DRIVE:   prdata = {24'd0, slow_drive_r};
      default:          prdata = 32'd0;
    endcase
  end

  // ---- handshake ----
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // ---- evaluation terms (from the latched beat) ----
  always_comb begin
    mode_v = run_mode_r;
    if (in_r.set_mode == REQ_CAL) mode_v = MODE_CAL;
    else if (in_r.set_mode == REQ_NORMAL) mode_v = MODE_NORMAL;
    tgt_v      = in_r.new_target ? in_r.target : target_now_r;
    delta      = {tgt_v[23], tgt_v} - {in_r.position[23], in_r.position};
    ad         = delta[24] ? 24'(-delta) : delta[23:0];
    pk         = (ad > peak_r) ? ad : peak_r;
    move_diff  = {in_r.position[23], in_r.position} - {last_pos_r[23], last_pos_r};
    move       = move_diff[24] ? 24'(-move_diff) : move_diff[23:0];
    travel_sum = {1'b0, travel_r} + {9'd0, move};
    travel_sat = travel_sum[32] ? 32'hFFFF_FFFF : travel_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      run_mode_r    <= MODE_CAL;
      target_now_r  <= '0;
      target_good_r <= '0;
      peak_r        <= '0;
      last_pos_r    <= '0;
      travel_r      <= '0;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      run_mode_r    <= run_mode_nxt;
      target_now_r  <= target_now_nxt;
      target_good_r <= target_good_nxt;
      peak_r        <= peak_nxt;
      last_pos_r    <= last_pos_nxt;
      travel_r      <= travel_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (in_valid && !in_stall) in_r <= in_data;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    run_mode_nxt    = run_mode_r;
    target_now_nxt  = target_now_r;
    target_good_nxt = target_good_r;
    peak_nxt        = peak_r;
    last_pos_nxt    = last_pos_r;
    travel_nxt      = travel_r;
    held_nxt        = held_r;
    neg_nxt         = neg_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && out_stall;
    ramp_req.go     = 1'b0;
    ramp_req.m      = ad;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt    = ST_DONE;
        run_mode_nxt = mode_v;
        if (mode_v == MODE_CAL) begin
          // calibrate: clear tracking, repeat held command
          target_now_nxt = '0;
          peak_nxt       = '0;
          last_pos_nxt   = '0;
          travel_nxt     = '0;
        end else if (tgt_v[23]) begin
          target_now_nxt = tgt_v;
          held_nxt       = '0;
        end else if (34'(tgt_v) * 34'd100 > TGT_LIM) begin
          // out-of-range target: restore last good one
          target_now_nxt = target_good_r;
        end else begin
          target_now_nxt  = tgt_v;
          target_good_nxt = tgt_v;
          peak_nxt        = pk;
          neg_nxt         = delta[24];
          if (delta != '0 && !(ad < {8'd0, dead_band_r})) begin
            if (28'd5 * 28'(pk) > (ONE << 1)) begin
              if (28'd5 * 28'(ad) + ONE > 28'd5 * 28'(pk)) begin
                ramp_req.go = 1'b1;
                ramp_req.m  = pk - ad;
                state_nxt   = ST_RAMP;
              end else if (28'd5 * 28'(ad) < ONE) begin
                ramp_req.go = 1'b1;
                ramp_req.m  = ad;
                state_nxt   = ST_RAMP;
              end else begin
                held_nxt = delta[24] ? -$signed(FULL_DRIVE) : $signed(FULL_DRIVE);
              end
            end else begin
              held_nxt = delta[24] ? -$signed({8'd0, slow_drive_r})
                                   : $signed({8'd0, slow_drive_r});
            end
          end else begin
            // on target or inside the dead band: stop, count travel
            held_nxt = '0;
            if (in_r.position != last_pos_r) begin
              travel_nxt   = travel_sat;
              last_pos_nxt = in_r.position;
              peak_nxt     = ad;
              if (travel_sat > {9'd0, travel_limit_r}) run_mode_nxt = MODE_CAL;
            end
          end
        end
      end
      ST_RAMP: begin
        if (ramp_done) begin
          held_nxt  = neg_r ? -$signed({1'b0, ramp_mag}) : $signed({1'b0, ramp_mag});
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_nxt.command  = held_r;
          out_nxt.mode_now = run_mode_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- assertions ----
  `TPDC_ASSERT_NEXT(a_accept_eval, in_valid && !in_stall, state_r == ST_EVAL)
  `TPDC_ASSERT_NOW(a_ramp_done_in_ramp, ramp_done, state_r == ST_RAMP)
  `TPDC_ASSERT_NEXT(a_load_valid, load_out, out_valid_r && out_data.mode_now == run_mode_r)
  `TPDC_ASSERT_NEXT(a_held_kept, out_valid_r && out_stall && state_r != ST_DONE, out_valid_r)

endmodule

[rtl/core/tpdc_ramp.sv]
// Bit-serial ramp magnitude unit: trunc(255*(b + 5*(1-b)*m)), saturated.
module tpdc_ramp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tpdc_pkg::ramp_req_t req,
  input  logic [15:0]         base_duty,
  output logic                done,
  output logic [14:0]         mag
);
  import tpdc_pkg::*;

  localparam int SHIFT = 16 + FRAC_BITS;

  ramp_state_t state_r, state_nxt;
  logic [40:0] p_r, p_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [44:0] x_r, x_nxt;
  logic [14:0] mag_r, mag_nxt;
  logic        done_r, done_nxt;

  logic [16:0] kb;
  logic [17:0] hi_sum;
  logic [52:0] num;
  logic [52:0] sh;

  assign kb     = 17'h10000 - {1'b0, base_duty};
  assign hi_sum = {1'b0, p_r[40:24]} + (p_r[0] ? {1'b0, kb} : 18'd0);
  assign num    = {x_r, 8'd0} - {8'd0, x_r};
  assign sh     = num >> SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    mag_r <= mag_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    mag_nxt   = mag_r;
    done_nxt  = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (req.go) begin
          p_nxt     = {17'd0, req.m};
          cnt_nxt   = 5'd0;
          state_nxt = R_MUL;
        end
      end
      R_MUL: begin
        // one multiplier bit per cycle, product shifts right
        p_nxt   = {hi_sum, p_r[23:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd23) state_nxt = R_SUM;
      end
      R_SUM: begin
        x_nxt     = (45'(base_duty) << FRAC_BITS) + {2'd0, p_r, 2'd0} + {4'd0, p_r};
        state_nxt = R_SCALE;
      end
      R_SCALE: begin
        mag_nxt   = (sh > 53'(MAG_SAT)) ? MAG_SAT : sh[14:0];
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  assign done = done_r;
  assign mag  = mag_r;

endmodule

[tb/sv/tb.sv]
// Testbench for the target position drive controller: random and directed samples, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpdc_pkg::*;

  localparam int FB = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  target_position_drive_controller #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of the registers and the tracking state.
  logic [15:0] m_base_duty, m_dead_band;
  logic [22:0] m_travel_limit;
  logic [7:0]  m_slow_drive;
  logic        m_mode;
  logic signed [23:0] m_target, m_target_good, m_last_pos;
  logic [23:0] m_peak;
  logic [31:0] m_travel;
  logic signed [15:0] m_held;

  in_beat_t  pending_beats[$];
  out_beat_t expected_cmds[$];
  int errors = 0;
  bit pause_sender = 0;
  bit long_hold = 0;

  // Ramp magnitude for distance m: trunc(255*(b + 5*(1-b)*m)), capped at 32767.
  function automatic logic [15:0] ramp_mag(input logic [63:0] m);
    logic [63:0] b, num, mag;
    b = m_base_duty;
    num = 64'd255 * ((b << FB) + 64'd5 * (64'd65536 - b) * m);
    mag = num >> (16 + FB);
    if (mag > 64'd32767) mag = 64'd32767;
    return mag[15:0];
  endfunction

  function automatic out_beat_t predict_drive(input in_beat_t s);
    logic [63:0] one, ad, pk, tr;
    logic signed [63:0] delta;
    logic [15:0] mag;
    logic in_band;
    out_beat_t r;
    one = 64'd1 << FB;
    if (s.set_mode == REQ_CAL) m_mode = MODE_CAL;
    else if (s.set_mode == REQ_NORMAL) m_mode = MODE_NORMAL;
    if (s.new_target) m_target = s.target;
    if (m_mode == MODE_CAL) begin
      m_target = 0; m_peak = 0; m_last_pos = 0; m_travel = 0;
    end else if (m_target < 0) begin
      m_held = 0;
    end else if (64'(m_target) * 100 > 64'd299 * one) begin
      // out of range target: fall back, keep command
      m_target = m_target_good;
    end else begin
      delta = 64'(m_target) - 64'(s.position);
      ad = (delta < 0) ? 64'(-delta) : 64'(delta);
      in_band = ad < 64'(m_dead_band);
      if (ad > 64'(m_peak)) m_peak = ad[23:0];
      pk = m_peak;
      if (delta != 0 && !in_band) begin
        if (5 * pk > 2 * one) begin
          if (5 * ad + one > 5 * pk) mag = ramp_mag(pk - ad);
          else if (5 * ad < one) mag = ramp_mag(ad);
          else mag = FULL_DRIVE;
        end else begin
          mag = 16'(m_slow_drive);
        end
        m_held = (delta > 0) ? $signed(mag) : -$signed(mag);
      end else begin
        m_held = 0;
        if (s.position != m_last_pos) begin
          tr = 64'(m_travel) + ((s.position >= m_last_pos) ?
               64'(64'(s.position) - 64'(m_last_pos)) :
               64'(64'(m_last_pos) - 64'(s.position)));
          if (tr > 64'hFFFF_FFFF) tr = 64'hFFFF_FFFF;
          m_travel = tr[31:0];
          m_last_pos = s.position;
          if (m_travel > 32'(m_travel_limit)) m_mode = MODE_CAL;
          m_peak = ad[23:0];
        end
      end
      m_target_good = m_target;
    end
    r.command = m_held;
    r.mode_now = m_mode;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: bursts with random gaps; valid independent of stall.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(predict_drive(in_data));
        void'(pending_beats.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_beats.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !pause_sender && pending_beats.size() != 0) begin
        in_valid <= 1;
        in_data <= pending_beats[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 12);
        end else burst_left <= burst_left - 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off.
  int stall_phase = 0;
  int hold_count = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (long_hold && hold_count < 400) begin
      hold_count <= hold_count + 1;
      out_stall <= 1;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 300) % 3 == 0) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < 40);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected beat, actual cmd=%0d mode=%0b", $time,
                 out_data.command, out_data.mode_now);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (out_data.command !== e.command) begin
          $display("%0t: command expected %0d actual %0d", $time, e.command,
                   out_data.command);
          errors++;
        end
        if (out_data.mode_now !== e.mode_now) begin
          $display("%0t: mode expected %0b actual %0b", $time, e.mode_now,
                   out_data.mode_now);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_BASE_DUTY:    m_base_duty = val[15:0];
      REG_DEAD_BAND:    m_dead_band = val[15:0];
      REG_TRAVEL_LIMIT: m_travel_limit = val[22:0];
      default:          m_slow_drive = val[7:0];
    endcase
  endtask

  task automatic drain_all();
    while (pending_beats.size() != 0 || expected_cmds.size() != 0 || in_valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_beat_t mk(input int pos, input bit nt, input int tgt,
                                  input logic [1:0] md);
    in_beat_t s;
    s.position = pos[23:0]; s.new_target = nt; s.target = tgt[23:0]; s.set_mode = md;
    return s;
  endfunction

  // Random moves: targets mostly in 0..3.2, some negative or random; positions near or far.
  task automatic queue_moves(input int n);
    int tgt, pos, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        pending_beats.push_back(mk($urandom, $urandom_range(0, 1), $urandom,
                                    $urandom_range(0, 3)));
      end else if (k < 20) begin
        tgt = $urandom_range(0, 209715);
        pending_beats.push_back(mk($urandom_range(0, 209715), 1, tgt,
                                    ($urandom_range(0, 1)) ? REQ_NORMAL : 2'd0));
      end else begin
        tgt = (k < 24) ? -$urandom_range(1, 70000) : $urandom_range(0, 196000);
        pos = tgt + $urandom_range(0, 400) - 200;
        if (k < 60) pos = $urandom_range(0, 196000);
        pending_beats.push_back(mk(pos, (k < 40), tgt,
                                    (k < 30) ? REQ_NORMAL : 2'd0));
      end
    end
  endtask

  int settings[4][4];
  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    m_base_duty = RST_BASE_DUTY; m_dead_band = RST_DEAD_BAND;
    m_travel_limit = RST_TRAVEL_LIMIT; m_slow_drive = RST_SLOW_DRIVE;
    m_mode = MODE_CAL; m_target = 0; m_target_good = 0; m_last_pos = 0;
    m_peak = 0; m_travel = 0; m_held = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, each mode request, negative and too-large targets.
    pending_beats.push_back(mk(0, 1, 65536, REQ_CAL));
    pending_beats.push_back(mk(0, 1, 65536, REQ_NORMAL));
    pending_beats.push_back(mk(-8388608, 0, 0, 2'd3));
    pending_beats.push_back(mk(8388607, 1, 8388607, 2'd0));
    pending_beats.push_back(mk(100, 1, -8388608, 2'd0));
    pending_beats.push_back(mk(100, 1, 195952, 2'd0));
    pending_beats.push_back(mk(100, 1, 195953, 2'd0));
    pending_beats.push_back(mk(0, 1, 150000, 2'd0));
    pending_beats.push_back(mk(30000, 0, 0, 2'd0));
    pending_beats.push_back(mk(100000, 0, 0, 2'd0));
    pending_beats.push_back(mk(140000, 0, 0, 2'd0));
    pending_beats.push_back(mk(150000, 0, 0, 2'd0));
    pending_beats.push_back(mk(149900, 0, 0, 2'd0));
    pending_beats.push_back(mk(10000, 1, 20000, 2'd0));
    pending_beats.push_back(mk(20000, 0, 0, REQ_CAL));
    pending_beats.push_back(mk(-1, 1, 1, REQ_NORMAL));
    pending_beats.push_back(mk(0, 1, 0, 2'd0));
    drain_all();

    settings = '{'{0, 0, 0, 0}, '{65535, 65535, 8388607, 255},
                 '{10289, 197, 100000, 60}, '{40000, 3000, 500, 1}};
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 4; r++) reg_write(r[1:0], settings[ph][r]);
      queue_moves(270);
      if (ph == 1) begin
        long_hold = 1;
      end
      drain_all();
      // partway through the next batch the sender pauses until all results are back
      queue_moves(200);
      while (pending_beats.size() > 100) @(posedge clk);
      pause_sender = 1;
      while (expected_cmds.size() != 0 || in_valid) @(posedge clk);
      pause_sender = 0;
      drain_all();
    end
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tpdc_pkg.sv
rtl/core/tpdc_ramp.sv
rtl/core/target_position_drive_controller.sv
tb/sv/tb.sv
